@@ rtl/core/bba_pkg.sv @@
// Shared constants, codes and controller-to-datapath types for the bitmap block allocator.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package bba_pkg;

  localparam int CYLINDERS           = 8;
  localparam int TRACKS_PER_CYLINDER = 2;
  localparam int RECORDS_PER_TRACK   = 4;
  localparam int JOB_ID_BITS         = 8;

  localparam int PER_CYL = TRACKS_PER_CYLINDER * RECORDS_PER_TRACK;
  localparam int BLOCKS  = CYLINDERS * PER_CYL;
  localparam int IDX_W   = $clog2(BLOCKS);
  localparam int CNT_W   = 7;

  localparam int ACTION_W = 2;
  localparam int NEED_W   = 7;
  localparam int CYL_W    = 3;
  localparam int TRK_W    = 1;
  localparam int REC_W    = 2;
  localparam int MAP_W    = 64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RECLAIM = 2'd1,
    ACT_REPORT  = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_ALLOC   = 3'd0,
    ST_FREED   = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_NOJOB   = 3'd3,
    ST_NOTHING = 3'd4,
    ST_REPORT  = 3'd5
  } status_t;

  typedef struct packed {
    logic    load;
    logic    single;
    status_t single_status;
    logic    alloc_step;
    logic    recl_read;
    logic    recl_final;
  } bba_cmd_t;

  typedef struct packed {
    logic need_zero;
    logic no_space;
    logic alloc_fin;
    logic read_last;
  } bba_stat_t;

endpackage

@@ rtl/core/bba_ctrl.sv @@
// Sequencing state machine of the bitmap block allocator.
// Depends on bba_pkg for the command and status structs and the action codes.
module bba_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bba_pkg::ACTION_W-1:0] in_action,
  input  bba_pkg::bba_stat_t           stat,
  output bba_pkg::bba_cmd_t            cmd,
  output logic                         busy
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ALLOC = 5'b00010,
    S_RECL  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt         = state_r;
    cmd               = '0;
    cmd.single_status = bba_pkg::ST_NOTHING;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (bba_pkg::action_t'(in_action))
            bba_pkg::ACT_ALLOC: begin
              if (stat.need_zero) begin
                cmd.single        = 1'b1;
                cmd.single_status = bba_pkg::ST_NOTHING;
              end else if (stat.no_space) begin
                cmd.single        = 1'b1;
                cmd.single_status = bba_pkg::ST_NOSPACE;
              end else begin
                cmd.load  = 1'b1;
                state_nxt = S_ALLOC;
              end
            end
            bba_pkg::ACT_RECLAIM: begin
              cmd.load  = 1'b1;
              state_nxt = S_RECL;
            end
            bba_pkg::ACT_REPORT: begin
              cmd.single        = 1'b1;
              cmd.single_status = bba_pkg::ST_REPORT;
            end
            default: begin
            end
          endcase
        end
      end
      S_ALLOC: begin
        cmd.alloc_step = 1'b1;
        if (stat.alloc_fin) begin
          state_nxt = S_IDLE;
        end
      end
      S_RECL: begin
        cmd.recl_read = 1'b1;
        if (stat.read_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.recl_final = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ rtl/core/bba_dp.sv @@
// Datapath of the bitmap block allocator: used bitmap, owner memory, free count and result beat.
// Depends on bba_pkg; driven by the command struct from bba_ctrl.
module bba_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bba_pkg::bba_cmd_t              cmd,
  input  logic [bba_pkg::JOB_ID_BITS-1:0] in_job_id,
  input  logic [bba_pkg::NEED_W-1:0]     in_blocks_needed,
  output bba_pkg::bba_stat_t             stat,
  output logic                           out_valid,
  output logic [2:0]                     out_status,
  output logic [bba_pkg::CYL_W-1:0]      out_cylinder,
  output logic [bba_pkg::TRK_W-1:0]      out_track,
  output logic [bba_pkg::REC_W-1:0]      out_record,
  output logic [bba_pkg::MAP_W-1:0]      out_used_map,
  output logic [bba_pkg::CNT_W-1:0]      out_free_count,
  output logic                           out_last
);

  logic [bba_pkg::JOB_ID_BITS-1:0] owner_mem [bba_pkg::BLOCKS];

  logic [bba_pkg::BLOCKS-1:0]      used_r, used_nxt;
  logic [bba_pkg::CNT_W-1:0]       free_r, free_nxt;
  logic [bba_pkg::CNT_W-1:0]       snap_r;
  logic [bba_pkg::JOB_ID_BITS-1:0] job_r;
  logic [bba_pkg::NEED_W-1:0]      need_r, need_nxt;
  logic [bba_pkg::IDX_W-1:0]       cnt_r, cnt_nxt;
  logic [bba_pkg::JOB_ID_BITS-1:0] rd_r;
  logic                            pv_r;
  logic [bba_pkg::IDX_W-1:0]       pidx_r;
  logic                            hold_v_r, hold_v_nxt;
  logic [bba_pkg::IDX_W-1:0]       hold_idx_r, hold_idx_nxt;

  logic                            out_valid_r, out_valid_nxt;
  bba_pkg::status_t                out_status_r, out_status_nxt;
  logic                            out_named_nxt;
  logic [bba_pkg::IDX_W-1:0]       out_idx_nxt;
  logic [bba_pkg::CYL_W-1:0]       out_cyl_r;
  logic [bba_pkg::TRK_W-1:0]       out_trk_r;
  logic [bba_pkg::REC_W-1:0]       out_rec_r;
  logic [bba_pkg::MAP_W-1:0]       out_map_r, out_map_nxt;
  logic [bba_pkg::CNT_W-1:0]       out_free_r, out_free_nxt;
  logic                            out_last_r, out_last_nxt;

  logic grant;
  logic hit;

  assign grant = cmd.alloc_step && !used_r[cnt_r];
  assign hit   = pv_r && used_r[pidx_r] && (rd_r == job_r);

  assign stat.need_zero = (in_blocks_needed == '0);
  assign stat.no_space  = (in_blocks_needed > free_r);
  assign stat.alloc_fin = grant && (need_r == bba_pkg::NEED_W'(1));
  assign stat.read_last = (cnt_r == bba_pkg::IDX_W'(bba_pkg::BLOCKS - 1));

  always_comb begin
    used_nxt       = used_r;
    free_nxt       = free_r;
    need_nxt       = need_r;
    cnt_nxt        = cnt_r;
    hold_v_nxt     = hold_v_r;
    hold_idx_nxt   = hold_idx_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = bba_pkg::ST_NOTHING;
    out_named_nxt  = 1'b0;
    out_idx_nxt    = '0;
    out_map_nxt    = '0;
    out_free_nxt   = snap_r;
    out_last_nxt   = 1'b0;

    if (cmd.load) begin
      need_nxt   = in_blocks_needed;
      cnt_nxt    = '0;
      hold_v_nxt = 1'b0;
    end

    if (cmd.single) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = cmd.single_status;
      out_free_nxt   = free_r;
      out_last_nxt   = 1'b1;
      if (cmd.single_status == bba_pkg::ST_REPORT) begin
        out_map_nxt = bba_pkg::MAP_W'(used_r);
      end
    end

    if (cmd.alloc_step) begin
      cnt_nxt = cnt_r + 1'b1;
      if (grant) begin
        used_nxt[cnt_r] = 1'b1;
        free_nxt        = free_r - 1'b1;
        need_nxt        = need_r - 1'b1;
        out_valid_nxt   = 1'b1;
        out_status_nxt  = bba_pkg::ST_ALLOC;
        out_named_nxt   = 1'b1;
        out_idx_nxt     = cnt_r;
        out_last_nxt    = (need_r == bba_pkg::NEED_W'(1));
      end
    end

    if (cmd.recl_read) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    if (hit) begin
      used_nxt[pidx_r] = 1'b0;
      free_nxt         = free_r + 1'b1;
      hold_v_nxt       = 1'b1;
      hold_idx_nxt     = pidx_r;
      if (hold_v_r) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = bba_pkg::ST_FREED;
        out_named_nxt  = 1'b1;
        out_idx_nxt    = hold_idx_r;
      end
    end

    if (cmd.recl_final) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      if (hold_v_r) begin
        out_status_nxt = bba_pkg::ST_FREED;
        out_named_nxt  = 1'b1;
        out_idx_nxt    = hold_idx_r;
      end else begin
        out_status_nxt = bba_pkg::ST_NOJOB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_step && grant) begin
      owner_mem[cnt_r] <= job_r;
    end
    if (cmd.recl_read) begin
      rd_r <= owner_mem[cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      free_r      <= bba_pkg::CNT_W'(bba_pkg::BLOCKS);
      pv_r        <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      free_r      <= free_nxt;
      pv_r        <= cmd.recl_read;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      snap_r <= free_r;
      job_r  <= in_job_id;
    end
    need_r       <= need_nxt;
    cnt_r        <= cnt_nxt;
    pidx_r       <= cnt_r;
    hold_idx_r   <= hold_idx_nxt;
    out_status_r <= out_status_nxt;
    out_cyl_r    <= out_named_nxt ? bba_pkg::CYL_W'(out_idx_nxt / bba_pkg::PER_CYL) : '0;
    out_trk_r    <= out_named_nxt ?
                    bba_pkg::TRK_W'((out_idx_nxt / bba_pkg::RECORDS_PER_TRACK)
                                    % bba_pkg::TRACKS_PER_CYLINDER) : '0;
    out_rec_r    <= out_named_nxt ?
                    bba_pkg::REC_W'(out_idx_nxt % bba_pkg::RECORDS_PER_TRACK) : '0;
    out_map_r    <= out_map_nxt;
    out_free_r   <= out_free_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_cylinder   = out_cyl_r;
  assign out_track      = out_trk_r;
  assign out_record     = out_rec_r;
  assign out_used_map   = out_map_r;
  assign out_free_count = out_free_r;
  assign out_last       = out_last_r;

  a_free_tracks_map: assert property (@(posedge clk) disable iff (!rst_n)
    int'(free_r) == bba_pkg::BLOCKS - $countones(used_r))
    else $error("free count disagrees with the used bitmap");

  a_grant_needs_demand: assert property (@(posedge clk) disable iff (!rst_n)
    grant |-> need_r != '0)
    else $error("block claimed with no demand left");

  a_final_beat_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.recl_final |=> out_valid_r && out_last_r)
    else $error("reclaim ended without a final beat");

  a_hit_clears_owned: assert property (@(posedge clk) disable iff (!rst_n)
    hit |=> !used_r[$past(pidx_r)] && !hold_v_r == 1'b0)
    else $error("freed block still marked used");

endmodule

@@ rtl/core/bitmap_block_allocator.sv @@
// Top level of the bitmap block allocator: joins the controller and the datapath.
// Depends on bba_pkg, bba_ctrl and bba_dp.
//
// A 64-block disk is tracked by a used bitmap with an owner job id per block. An item is taken
// when start is high and busy is low; results appear as beats marked by out_valid, each present
// for exactly one cycle, and the receiver cannot stall them. Report, zero-block allocate and
// no-space allocate give one beat the cycle after the item and leave busy low. An allocate that
// succeeds scans one block per cycle and finishes on the cycle of the last claimed block, holding
// busy until then. A reclaim reads the owner memory through its single read port one block per
// cycle, then drains the read pipeline and gives the closing beat, with busy high throughout.
// A freed block is reported one hit late, so that the final beat can carry last.
module bitmap_block_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [bba_pkg::ACTION_W-1:0]    in_action,
  input  logic [bba_pkg::JOB_ID_BITS-1:0] in_job_id,
  input  logic [bba_pkg::NEED_W-1:0]      in_blocks_needed,
  output logic                            out_valid,
  output logic [2:0]                      out_status,
  output logic [bba_pkg::CYL_W-1:0]       out_cylinder,
  output logic [bba_pkg::TRK_W-1:0]       out_track,
  output logic [bba_pkg::REC_W-1:0]       out_record,
  output logic [bba_pkg::MAP_W-1:0]       out_used_map,
  output logic [bba_pkg::CNT_W-1:0]       out_free_count,
  output logic                            out_last
);

  bba_pkg::bba_cmd_t  cmd;
  bba_pkg::bba_stat_t stat;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  bba_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_job_id        (in_job_id),
    .in_blocks_needed (in_blocks_needed),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_cylinder     (out_cylinder),
    .out_track        (out_track),
    .out_record       (out_record),
    .out_used_map     (out_used_map),
    .out_free_count   (out_free_count),
    .out_last         (out_last)
  );

endmodule

@@ dv/tb_bitmap_block_allocator.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_block_allocator: directed and random allocate, reclaim
// and report traffic, checked beat by beat against a model of the bitmap and block owners.
// Depends on bba_pkg and the RTL top level bitmap_block_allocator.
module tb_bitmap_block_allocator;

  localparam int RANDOM_ITEMS   = 256;
  localparam int IDLE_PERCENT   = 12;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    bba_pkg::status_t              status;
    logic [bba_pkg::CYL_W-1:0]     cylinder;
    logic [bba_pkg::TRK_W-1:0]     track;
    logic [bba_pkg::REC_W-1:0]     record;
    logic [bba_pkg::MAP_W-1:0]     used_map;
    logic [bba_pkg::CNT_W-1:0]     free_count;
    logic                          last;
  } block_beat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [bba_pkg::ACTION_W-1:0]    in_action;
  logic [bba_pkg::JOB_ID_BITS-1:0] in_job_id;
  logic [bba_pkg::NEED_W-1:0]      in_blocks_needed;
  logic                            out_valid;
  logic [2:0]                      out_status;
  logic [bba_pkg::CYL_W-1:0]       out_cylinder;
  logic [bba_pkg::TRK_W-1:0]       out_track;
  logic [bba_pkg::REC_W-1:0]       out_record;
  logic [bba_pkg::MAP_W-1:0]       out_used_map;
  logic [bba_pkg::CNT_W-1:0]       out_free_count;
  logic                            out_last;

  logic [bba_pkg::BLOCKS-1:0]      used_blocks_model = '0;
  logic [bba_pkg::JOB_ID_BITS-1:0] owner_model [bba_pkg::BLOCKS];
  block_beat_t                     expected_beats [$];
  block_beat_t                     head_beat;

  bit idle_on = 1'b1;
  int items_taken;
  int ignored_items;
  int beats_checked;
  int mismatches;
  int quiet_cycles;

  bitmap_block_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_job_id        (in_job_id),
    .in_blocks_needed (in_blocks_needed),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_cylinder     (out_cylinder),
    .out_track        (out_track),
    .out_record       (out_record),
    .out_used_map     (out_used_map),
    .out_free_count   (out_free_count),
    .out_last         (out_last)
  );

  always #6 clk = ~clk;

  task automatic queue_beat(bba_pkg::status_t st, int blk, logic named,
                            logic [bba_pkg::MAP_W-1:0] map, int free_blocks, logic is_last);
    block_beat_t beat;
    beat.status     = st;
    beat.cylinder   = named ? bba_pkg::CYL_W'(blk / bba_pkg::PER_CYL) : '0;
    beat.track      = named ? bba_pkg::TRK_W'((blk / bba_pkg::RECORDS_PER_TRACK)
                                              % bba_pkg::TRACKS_PER_CYLINDER) : '0;
    beat.record     = named ? bba_pkg::REC_W'(blk % bba_pkg::RECORDS_PER_TRACK) : '0;
    beat.used_map   = map;
    beat.free_count = bba_pkg::CNT_W'(free_blocks);
    beat.last       = is_last;
    expected_beats.push_back(beat);
  endtask

  task automatic apply_disk_request(bba_pkg::action_t act,
                                    logic [bba_pkg::JOB_ID_BITS-1:0] job,
                                    logic [bba_pkg::NEED_W-1:0] need);
    int free_blocks;
    int remaining;
    int owned;
    free_blocks = bba_pkg::BLOCKS - $countones(used_blocks_model);
    case (act)
      bba_pkg::ACT_ALLOC: begin
        if (need == 0) begin
          queue_beat(bba_pkg::ST_NOTHING, 0, 1'b0, '0, free_blocks, 1'b1);
        end else if (int'(need) > free_blocks) begin
          queue_beat(bba_pkg::ST_NOSPACE, 0, 1'b0, '0, free_blocks, 1'b1);
        end else begin
          remaining = need;
          for (int b = 0; b < bba_pkg::BLOCKS && remaining > 0; b++) begin
            if (!used_blocks_model[b]) begin
              used_blocks_model[b] = 1'b1;
              owner_model[b] = job;
              remaining--;
              queue_beat(bba_pkg::ST_ALLOC, b, 1'b1, '0, free_blocks, remaining == 0);
            end
          end
        end
      end
      bba_pkg::ACT_RECLAIM: begin
        owned = 0;
        for (int b = 0; b < bba_pkg::BLOCKS; b++) begin
          if (used_blocks_model[b] && owner_model[b] == job) owned++;
        end
        if (owned == 0) begin
          queue_beat(bba_pkg::ST_NOJOB, 0, 1'b0, '0, free_blocks, 1'b1);
        end else begin
          for (int b = 0; b < bba_pkg::BLOCKS; b++) begin
            if (used_blocks_model[b] && owner_model[b] == job) begin
              used_blocks_model[b] = 1'b0;
              owned--;
              queue_beat(bba_pkg::ST_FREED, b, 1'b1, '0, free_blocks, owned == 0);
            end
          end
        end
      end
      bba_pkg::ACT_REPORT: begin
        queue_beat(bba_pkg::ST_REPORT, 0, 1'b0, bba_pkg::MAP_W'(used_blocks_model),
                   free_blocks, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      apply_disk_request(bba_pkg::action_t'(in_action), in_job_id, in_blocks_needed);
      if (in_action == bba_pkg::ACT_NONE) ignored_items++;
      else items_taken++;
    end
    if (rst_n && out_valid) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with status %0d arrived with nothing expected", out_status);
        mismatches++;
      end else begin
        head_beat = expected_beats.pop_front();
        beats_checked++;
        check_field("status", head_beat.status, out_status);
        check_field("cylinder", head_beat.cylinder, out_cylinder);
        check_field("track", head_beat.track, out_track);
        check_field("record", head_beat.record, out_record);
        check_field("used_map", head_beat.used_map, out_used_map);
        check_field("free_count", head_beat.free_count, out_free_count);
        check_field("last", head_beat.last, out_last);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_item(bba_pkg::action_t act, logic [bba_pkg::JOB_ID_BITS-1:0] job,
                           logic [bba_pkg::NEED_W-1:0] need);
    while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    in_action        <= act;
    in_job_id        <= job;
    in_blocks_needed <= need;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic test_empty_disk();
    send_item(bba_pkg::ACT_REPORT, 8'h00, 7'd0);
    send_item(bba_pkg::ACT_ALLOC, 8'h00, 7'd0);
    send_item(bba_pkg::ACT_RECLAIM, 8'h00, 7'd0);
    send_item(bba_pkg::ACT_ALLOC, 8'h00, 7'd127);
    send_item(bba_pkg::ACT_ALLOC, 8'h01, 7'd65);
  endtask

  task automatic test_full_disk();
    send_item(bba_pkg::ACT_ALLOC, 8'hFF, 7'd64);
    send_item(bba_pkg::ACT_REPORT, 8'hFF, 7'd127);
    send_item(bba_pkg::ACT_ALLOC, 8'h00, 7'd1);
    send_item(bba_pkg::ACT_RECLAIM, 8'h00, 7'd0);
    send_item(bba_pkg::ACT_RECLAIM, 8'hFF, 7'd0);
  endtask

  task automatic test_first_fit_holes();
    send_item(bba_pkg::ACT_ALLOC, 8'h01, 7'd3);
    send_item(bba_pkg::ACT_ALLOC, 8'h02, 7'd5);
    send_item(bba_pkg::ACT_ALLOC, 8'h01, 7'd2);
    send_item(bba_pkg::ACT_RECLAIM, 8'h01, 7'd0);
    send_item(bba_pkg::ACT_ALLOC, 8'h03, 7'd4);
    send_item(bba_pkg::ACT_REPORT, 8'h00, 7'd0);
    send_item(bba_pkg::ACT_ALLOC, 8'h5A, 7'd56);
    send_item(bba_pkg::ACT_ALLOC, 8'h5A, 7'd55);
    send_item(bba_pkg::ACT_RECLAIM, 8'h02, 7'd0);
    send_item(bba_pkg::ACT_RECLAIM, 8'h03, 7'd0);
    send_item(bba_pkg::ACT_RECLAIM, 8'h5A, 7'd0);
    send_item(bba_pkg::ACT_REPORT, 8'h00, 7'd0);
  endtask

  task automatic test_unused_action();
    send_item(bba_pkg::ACT_NONE, 8'hFF, 7'd127);
    send_item(bba_pkg::ACT_REPORT, 8'h00, 7'd0);
  endtask

  task automatic test_random_traffic();
    logic [bba_pkg::JOB_ID_BITS-1:0] job_pool [6];
    logic [bba_pkg::JOB_ID_BITS-1:0] job;
    logic [bba_pkg::NEED_W-1:0]      need;
    int                              counted;
    int                              pick;
    int                              size_pick;
    foreach (job_pool[i]) job_pool[i] = bba_pkg::JOB_ID_BITS'($urandom_range(0, 255));
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      idle_on = !(counted >= 100 && counted < 180);
      pick = $urandom_range(0, 99);
      job  = job_pool[$urandom_range(0, 5)];
      if (pick < 50) begin
        size_pick = $urandom_range(0, 99);
        if (size_pick < 80) need = bba_pkg::NEED_W'($urandom_range(1, 6));
        else if (size_pick < 90) need = bba_pkg::NEED_W'($urandom_range(7, 64));
        else if (size_pick < 95) need = bba_pkg::NEED_W'($urandom_range(65, 127));
        else need = '0;
        send_item(bba_pkg::ACT_ALLOC, job, need);
        counted++;
      end else if (pick < 82) begin
        if ($urandom_range(0, 9) == 0) job = bba_pkg::JOB_ID_BITS'($urandom_range(0, 255));
        send_item(bba_pkg::ACT_RECLAIM, job, bba_pkg::NEED_W'($urandom_range(0, 127)));
        counted++;
      end else if (pick < 96) begin
        send_item(bba_pkg::ACT_REPORT, bba_pkg::JOB_ID_BITS'($urandom_range(0, 255)),
                  bba_pkg::NEED_W'($urandom_range(0, 127)));
        counted++;
      end else begin
        send_item(bba_pkg::ACT_NONE, bba_pkg::JOB_ID_BITS'($urandom_range(0, 255)),
                  bba_pkg::NEED_W'($urandom_range(0, 127)));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_action        <= bba_pkg::ACT_REPORT;
    in_job_id        <= '0;
    in_blocks_needed <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_disk();
    test_full_disk();
    test_first_fit_holes();
    test_unused_action();
    test_random_traffic();
    start <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d allocate, reclaim and report items plus %0d ignored items,",
             items_taken, ignored_items);
    $display("with %0d result beats compared and %0d mismatches.", beats_checked, mismatches);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
